### src/cyk_membership_parser_core_macros.svh
// assertion macros shared by the cyk membership parser rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef CYK_MEMBERSHIP_PARSER_CORE_MACROS_SVH
`define CYK_MEMBERSHIP_PARSER_CORE_MACROS_SVH

// same-cycle implication, checked at every rising clock edge outside reset
`define CYK_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CYK_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/cyk_mp_pkg.sv
// shared types and constants of the cyk membership parser
// no dependencies; used by every module of the block
`default_nettype none

package cyk_mp_pkg;

   // fixed field widths
   localparam int FUNC_W      = 2;
   localparam int RULE_IDX_W  = 6;
   localparam int VAR_W       = 4;
   localparam int SYM_W       = 4;
   localparam int BIN_CNT_W   = 7;
   localparam int TERM_CNT_W  = 6;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 7;

   // transaction function codes
   localparam logic [FUNC_W-1:0] FUNC_LOAD_BIN  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOAD_TERM = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_SYMBOL    = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BIN_COUNT  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TERM_COUNT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LEAF,
      ST_SPLIT,
      ST_DRAIN,
      ST_WRITE,
      ST_DONE
   } seq_state_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } chart_cmd_type;

   typedef struct packed {
      logic idle;
      logic full;
   } seq_status_type;

endpackage

`default_nettype wire

### src/cyk_mp_chart.sv
// chart memory: one write port, two registered read ports
// depends on cyk_mp_pkg for the command struct
`default_nettype none

module cyk_mp_chart #(
   parameter int LW = 5,
   parameter int CW = 16
) (
   input  wire                          clock,
   input  cyk_mp_pkg::chart_cmd_type    cmd,
   input  wire  [2*LW-1:0]              wr_addr,
   input  wire  [CW-1:0]                wr_data,
   input  wire  [2*LW-1:0]              rd_addr_a,
   input  wire  [2*LW-1:0]              rd_addr_b,
   output logic [CW-1:0]                rd_data_a,
   output logic [CW-1:0]                rd_data_b
);

   localparam int DEPTH = 1 << (2*LW);

   logic [CW-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

`default_nettype wire

### src/cyk_mp_rules.sv
// rule tables with the leaf lookup and the split combine unit
// depends on cyk_mp_pkg for field widths
`default_nettype none

module cyk_mp_rules #(
   parameter int NV  = 16,
   parameter int NT  = 16,
   parameter int NB  = 64,
   parameter int NTR = 32
) (
   input  wire                                   clock,
   input  wire                                   load_bin,
   input  wire                                   load_term,
   input  wire  [cyk_mp_pkg::RULE_IDX_W-1:0]     rule_index,
   input  wire  [cyk_mp_pkg::VAR_W-1:0]          lhs,
   input  wire  [cyk_mp_pkg::VAR_W-1:0]          first,
   input  wire  [cyk_mp_pkg::VAR_W-1:0]          second,
   input  wire  [cyk_mp_pkg::BIN_CNT_W-1:0]      bin_count,
   input  wire  [cyk_mp_pkg::TERM_CNT_W-1:0]     term_count,
   input  wire  [cyk_mp_pkg::SYM_W-1:0]          sym,
   input  wire  [NV-1:0]                         left,
   input  wire  [NV-1:0]                         right,
   output logic [NV-1:0]                         leaf,
   output logic [NV-1:0]                         hit
);

   localparam int XW = (NV > 16) ? NV : 16;

   logic [cyk_mp_pkg::VAR_W-1:0] ba_ff [NB];
   logic [cyk_mp_pkg::VAR_W-1:0] bb_ff [NB];
   logic [cyk_mp_pkg::VAR_W-1:0] bc_ff [NB];
   logic [cyk_mp_pkg::VAR_W-1:0] ta_ff [NTR];
   logic [cyk_mp_pkg::VAR_W-1:0] tt_ff [NTR];

   logic [XW-1:0] left_x;
   logic [XW-1:0] right_x;
   logic [XW-1:0] hit_x;
   logic [XW-1:0] leaf_x;

   always_ff @(posedge clock) begin
      for (int r = 0; r < NB; r++) begin
         if (load_bin && (32'(rule_index) == r)) begin
            ba_ff[r] <= lhs;
            bb_ff[r] <= first;
            bc_ff[r] <= second;
         end
      end
      for (int r = 0; r < NTR; r++) begin
         if (load_term && (32'(rule_index) == r)) begin
            ta_ff[r] <= lhs;
            tt_ff[r] <= first;
         end
      end
   end

   // leaf: every terminal rule whose terminal matches the symbol
   always_comb begin
      leaf_x = '0;
      for (int r = 0; r < NTR; r++) begin
         if ((32'(term_count) > r) && (32'(ta_ff[r]) < NV) && (32'(tt_ff[r]) < NT) &&
             (tt_ff[r] == sym)) begin
            leaf_x[ta_ff[r]] = 1'b1;
         end
      end
   end

   // one split: every binary rule checked against the left and right cells
   always_comb begin
      left_x  = XW'(left);
      right_x = XW'(right);
      hit_x   = '0;
      for (int r = 0; r < NB; r++) begin
         if ((32'(bin_count) > r) && (32'(ba_ff[r]) < NV) && (32'(bb_ff[r]) < NV) &&
             (32'(bc_ff[r]) < NV) && left_x[bb_ff[r]] && right_x[bc_ff[r]]) begin
            hit_x[ba_ff[r]] = 1'b1;
         end
      end
   end

   assign leaf = leaf_x[NV-1:0];
   assign hit  = hit_x[NV-1:0];

endmodule

`default_nettype wire

### src/cyk_mp_seq.sv
// sequencer: walks spans and splits of the chart, holds position and result
// depends on cyk_mp_pkg for state, command and status types
`default_nettype none

module cyk_mp_seq #(
   parameter int MAXL = 32,
   parameter int LW   = 5,
   parameter int CW   = 16
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              sym_valid,
   input  wire  [cyk_mp_pkg::SYM_W-1:0]     sym_in_data,
   input  wire                              last_in_data,
   input  wire  [CW-1:0]                    leaf,
   input  wire  [CW-1:0]                    hit,
   input  wire                              rsp_ready,
   output logic [cyk_mp_pkg::SYM_W-1:0]     sym,
   output cyk_mp_pkg::chart_cmd_type        cmd,
   output logic [2*LW-1:0]                  wr_addr,
   output logic [CW-1:0]                    wr_data,
   output logic [2*LW-1:0]                  rd_addr_a,
   output logic [2*LW-1:0]                  rd_addr_b,
   output cyk_mp_pkg::seq_status_type       status,
   output logic                             rsp_valid,
   output logic                             rsp_accepted,
   output logic                             rsp_overflow
);

   localparam int PW = $clog2(MAXL + 1);

   cyk_mp_pkg::seq_state_type state_ff, state_in;

   logic [PW-1:0]               pos_ff, pos_in;
   logic                        ovf_ff, ovf_in;
   logic [LW-1:0]               p_ff, p_in;
   logic [LW-1:0]               j_ff, j_in;
   logic [LW-1:0]               m_ff, m_in;
   logic [cyk_mp_pkg::SYM_W-1:0] sym_ff, sym_in;
   logic                        last_ff, last_in;
   logic                        top_ff, top_in;
   logic [CW-1:0]               acc_ff, acc_in;
   logic                        rdv_ff, rdv_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_acc_ff, rsp_acc_in;
   logic                        rsp_ovf_ff, rsp_ovf_in;
   logic                        full;
   logic                        rsp_free;

   assign full     = (pos_ff == PW'(MAXL));
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cyk_mp_pkg::ST_IDLE: begin
            if (sym_valid) begin
               if (!full) begin
                  state_in = cyk_mp_pkg::ST_LEAF;
               end else if (last_in_data) begin
                  state_in = cyk_mp_pkg::ST_DONE;
               end
            end
         end
         cyk_mp_pkg::ST_LEAF: begin
            if (p_ff != '0) begin
               state_in = cyk_mp_pkg::ST_SPLIT;
            end else if (last_ff) begin
               state_in = cyk_mp_pkg::ST_DONE;
            end else begin
               state_in = cyk_mp_pkg::ST_IDLE;
            end
         end
         cyk_mp_pkg::ST_SPLIT: begin
            if (m_ff == LW'(p_ff - 1'b1)) begin
               state_in = cyk_mp_pkg::ST_DRAIN;
            end
         end
         cyk_mp_pkg::ST_DRAIN: begin
            state_in = cyk_mp_pkg::ST_WRITE;
         end
         cyk_mp_pkg::ST_WRITE: begin
            if (j_ff != '0) begin
               state_in = cyk_mp_pkg::ST_SPLIT;
            end else if (last_ff) begin
               state_in = cyk_mp_pkg::ST_DONE;
            end else begin
               state_in = cyk_mp_pkg::ST_IDLE;
            end
         end
         cyk_mp_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = cyk_mp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cyk_mp_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs towards the chart
   always_comb begin
      cmd       = '0;
      wr_addr   = {j_ff, p_ff};
      wr_data   = acc_ff;
      rd_addr_a = {j_ff, m_ff};
      rd_addr_b = {LW'(m_ff + 1'b1), p_ff};
      case (state_ff)
         cyk_mp_pkg::ST_LEAF: begin
            cmd.wr_en = 1'b1;
            wr_addr   = {p_ff, p_ff};
            wr_data   = leaf;
         end
         cyk_mp_pkg::ST_SPLIT: begin
            cmd.rd_en = 1'b1;
         end
         cyk_mp_pkg::ST_WRITE: begin
            cmd.wr_en = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      pos_in       = pos_ff;
      ovf_in       = ovf_ff;
      p_in         = p_ff;
      j_in         = j_ff;
      m_in         = m_ff;
      sym_in       = sym_ff;
      last_in      = last_ff;
      top_in       = top_ff;
      acc_in       = rdv_ff ? (acc_ff | hit) : acc_ff;
      rdv_in       = (state_ff == cyk_mp_pkg::ST_SPLIT);
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_acc_in   = rsp_acc_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      case (state_ff)
         cyk_mp_pkg::ST_IDLE: begin
            if (sym_valid) begin
               last_in = last_in_data;
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  p_in   = pos_ff[LW-1:0];
                  sym_in = sym_in_data;
               end
            end
         end
         cyk_mp_pkg::ST_LEAF: begin
            pos_in = PW'(pos_ff + 1'b1);
            j_in   = LW'(p_ff - 1'b1);
            m_in   = LW'(p_ff - 1'b1);
            acc_in = '0;
            if (p_ff == '0) begin
               top_in = leaf[0];
            end
         end
         cyk_mp_pkg::ST_SPLIT: begin
            m_in = LW'(m_ff + 1'b1);
         end
         cyk_mp_pkg::ST_WRITE: begin
            j_in   = LW'(j_ff - 1'b1);
            m_in   = LW'(j_ff - 1'b1);
            acc_in = '0;
            if (j_ff == '0) begin
               top_in = acc_ff[0];
            end
         end
         cyk_mp_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_acc_in   = !ovf_ff && top_ff;
               rsp_ovf_in   = ovf_ff;
               pos_in       = '0;
               ovf_in       = 1'b0;
            end
         end
         default: begin
            pos_in = pos_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cyk_mp_pkg::ST_IDLE;
         pos_ff       <= '0;
         ovf_ff       <= 1'b0;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         ovf_ff       <= ovf_in;
         rdv_ff       <= rdv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      p_ff       <= p_in;
      j_ff       <= j_in;
      m_ff       <= m_in;
      sym_ff     <= sym_in;
      last_ff    <= last_in;
      top_ff     <= top_in;
      acc_ff     <= acc_in;
      rsp_acc_ff <= rsp_acc_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   assign sym          = sym_ff;
   assign status.idle  = (state_ff == cyk_mp_pkg::ST_IDLE);
   assign status.full  = full;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_accepted = rsp_acc_ff;
   assign rsp_overflow = rsp_ovf_ff;

endmodule

`default_nettype wire

### src/cyk_membership_parser_core.sv
// work: rule loads and unused codes complete as they are taken; a dropped symbol sets the
//   overflow flag; a symbol at position p writes its leaf cell and every span that ends at p
// throughput: one transaction at a time; the split loop through the chart
//   memory read ports (one split per cycle) sets the figure
// reset: synchronous, clears sequencer, position, overflow and rule counts;
//   rule tables and chart hold no reset and need no clearing pass
`default_nettype none

`include "cyk_membership_parser_core_macros.svh"

module cyk_membership_parser_core #(
   parameter int MAX_LENGTH         = 32,
   parameter int NUM_VARIABLES      = 16,
   parameter int NUM_TERMINALS      = 16,
   parameter int MAX_BINARY_RULES   = 64,
   parameter int MAX_TERMINAL_RULES = 32
) (
   input  wire                                   clock,
   input  wire                                   reset,
   // request channel
   input  wire                                   req_valid,
   output logic                                  req_ready,
   input  wire  [cyk_mp_pkg::FUNC_W-1:0]         req_func,
   input  wire  [cyk_mp_pkg::RULE_IDX_W-1:0]     req_rule_index,
   input  wire  [cyk_mp_pkg::VAR_W-1:0]          req_lhs_variable,
   input  wire  [cyk_mp_pkg::VAR_W-1:0]          req_rhs_first,
   input  wire  [cyk_mp_pkg::VAR_W-1:0]          req_rhs_second,
   input  wire  [cyk_mp_pkg::SYM_W-1:0]          req_symbol,
   input  wire                                   req_last_symbol,
   // response channel
   output logic                                  rsp_valid,
   input  wire                                   rsp_ready,
   output logic                                  rsp_accepted,
   output logic                                  rsp_overflow,
   // register write port
   input  wire                                   csr_we,
   input  wire  [cyk_mp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [cyk_mp_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // chart row and column index width
   localparam int LW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;

   logic [cyk_mp_pkg::BIN_CNT_W-1:0]  bin_count_ff;
   logic [cyk_mp_pkg::TERM_CNT_W-1:0] term_count_ff;

   logic                              req_fire;
   logic                              load_bin;
   logic                              load_term;
   logic                              sym_valid;
   logic [cyk_mp_pkg::SYM_W-1:0]      cur_sym;
   logic [NUM_VARIABLES-1:0]          leaf;
   logic [NUM_VARIABLES-1:0]          hit;
   logic [NUM_VARIABLES-1:0]          rd_data_a;
   logic [NUM_VARIABLES-1:0]          rd_data_b;
   logic [NUM_VARIABLES-1:0]          wr_data;
   logic [2*LW-1:0]                   wr_addr;
   logic [2*LW-1:0]                   rd_addr_a;
   logic [2*LW-1:0]                   rd_addr_b;
   cyk_mp_pkg::chart_cmd_type         chart_cmd;
   cyk_mp_pkg::seq_status_type        status;

   // transaction decode; requests are taken only while the sequencer idles
   assign req_ready = status.idle;
   assign req_fire  = req_valid && req_ready;
   assign load_bin  = req_fire && (req_func == cyk_mp_pkg::FUNC_LOAD_BIN);
   assign load_term = req_fire && (req_func == cyk_mp_pkg::FUNC_LOAD_TERM);
   assign sym_valid = req_fire && (req_func == cyk_mp_pkg::FUNC_SYMBOL);

   // rule counts; the user must write them only while idle, the block does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         bin_count_ff  <= '0;
         term_count_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            cyk_mp_pkg::CSR_BIN_COUNT: begin
               bin_count_ff <= csr_wdata[cyk_mp_pkg::BIN_CNT_W-1:0];
            end
            cyk_mp_pkg::CSR_TERM_COUNT: begin
               term_count_ff <= csr_wdata[cyk_mp_pkg::TERM_CNT_W-1:0];
            end
            default: begin
               bin_count_ff <= bin_count_ff;
            end
         endcase
      end
   end

   // rule tables, leaf lookup and the shared split unit
   cyk_mp_rules #(
      .NV  (NUM_VARIABLES),
      .NT  (NUM_TERMINALS),
      .NB  (MAX_BINARY_RULES),
      .NTR (MAX_TERMINAL_RULES)
   ) u_rules (
      .clock      (clock),
      .load_bin   (load_bin),
      .load_term  (load_term),
      .rule_index (req_rule_index),
      .lhs        (req_lhs_variable),
      .first      (req_rhs_first),
      .second     (req_rhs_second),
      .bin_count  (bin_count_ff),
      .term_count (term_count_ff),
      .sym        (cur_sym),
      .left       (rd_data_a),
      .right      (rd_data_b),
      .leaf       (leaf),
      .hit        (hit)
   );

   // chart of variable sets per span
   cyk_mp_chart #(
      .LW (LW),
      .CW (NUM_VARIABLES)
   ) u_chart (
      .clock     (clock),
      .cmd       (chart_cmd),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // span and split sequencer with the response register
   cyk_mp_seq #(
      .MAXL (MAX_LENGTH),
      .LW   (LW),
      .CW   (NUM_VARIABLES)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .sym_valid    (sym_valid),
      .sym_in_data  (req_symbol),
      .last_in_data (req_last_symbol),
      .leaf         (leaf),
      .hit          (hit),
      .rsp_ready    (rsp_ready),
      .sym          (cur_sym),
      .cmd          (chart_cmd),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .rd_addr_a    (rd_addr_a),
      .rd_addr_b    (rd_addr_b),
      .status       (status),
      .rsp_valid    (rsp_valid),
      .rsp_accepted (rsp_accepted),
      .rsp_overflow (rsp_overflow)
   );

   // an overflowed string is never accepted
   `CYK_ASSERT_IMP(a_ovf_rejects, clock, reset, rsp_valid && rsp_overflow, !rsp_accepted, "overflow with accept")
   // a symbol that still fits starts chart work and blocks further requests
   `CYK_ASSERT_NXT(a_sym_busy, clock, reset, sym_valid && !status.full, !req_ready, "ready during chart work")
   // a fresh response only comes out of the busy sequencer
   `CYK_ASSERT_IMP(a_rsp_from_busy, clock, reset, $rose(rsp_valid), !$past(req_ready), "response while idle")

endmodule

`default_nettype wire

### tb/tb.sv
// self-checking testbench of the cyk membership parser core
// depends on cyk_mp_pkg and cyk_membership_parser_core; the predictor is built in
`timescale 1ns / 100ps
`default_nettype none

module tb;

   // code of the unused function, which the block must swallow silently
   localparam logic [cyk_mp_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int LEN_MAX   = 32;
   localparam int BIN_SLOTS = 64;
   localparam int TERM_SLOTS = 32;
   // settle time covers a symbol near the end of a full string
   localparam int SETTLE_CYCLES = 2000;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [cyk_mp_pkg::FUNC_W-1:0]     func;
      logic [cyk_mp_pkg::RULE_IDX_W-1:0] slot;
      logic [cyk_mp_pkg::VAR_W-1:0]      lhs;
      logic [cyk_mp_pkg::VAR_W-1:0]      first;
      logic [cyk_mp_pkg::VAR_W-1:0]      second;
      logic [cyk_mp_pkg::SYM_W-1:0]      sym;
      logic                              last;
   } parse_req_type;

   typedef struct packed {
      logic accepted;
      logic overflow;
   } verdict_type;

   localparam int REQ_W = $bits(parse_req_type);

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic [cyk_mp_pkg::FUNC_W-1:0]     req_func = '0;
   logic [cyk_mp_pkg::RULE_IDX_W-1:0] req_rule_index = '0;
   logic [cyk_mp_pkg::VAR_W-1:0]      req_lhs_variable = '0;
   logic [cyk_mp_pkg::VAR_W-1:0]      req_rhs_first = '0;
   logic [cyk_mp_pkg::VAR_W-1:0]      req_rhs_second = '0;
   logic [cyk_mp_pkg::SYM_W-1:0]      req_symbol = '0;
   logic                              req_last_symbol = 1'b0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic                              rsp_accepted;
   logic                              rsp_overflow;
   logic                              csr_we = 1'b0;
   logic [cyk_mp_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [cyk_mp_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   cyk_membership_parser_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_rule_index   (req_rule_index),
      .req_lhs_variable (req_lhs_variable),
      .req_rhs_first    (req_rhs_first),
      .req_rhs_second   (req_rhs_second),
      .req_symbol       (req_symbol),
      .req_last_symbol  (req_last_symbol),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_accepted     (rsp_accepted),
      .rsp_overflow     (rsp_overflow),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #1 clock = ~clock;

   // queues between stimulus, predictor and checker
   parse_req_type pending_reqs[$];
   verdict_type   expected_verdicts[$];
   int            error_count = 0;

   // predictor state: rule tables, counts and the chart of variable sets
   logic [cyk_mp_pkg::VAR_W-1:0]      bin_lhs[BIN_SLOTS];
   logic [cyk_mp_pkg::VAR_W-1:0]      bin_left[BIN_SLOTS];
   logic [cyk_mp_pkg::VAR_W-1:0]      bin_right[BIN_SLOTS];
   logic [cyk_mp_pkg::VAR_W-1:0]      term_lhs[TERM_SLOTS];
   logic [cyk_mp_pkg::SYM_W-1:0]      term_sym[TERM_SLOTS];
   logic [cyk_mp_pkg::BIN_CNT_W-1:0]  bin_count = '0;
   logic [cyk_mp_pkg::TERM_CNT_W-1:0] term_count = '0;
   logic [15:0]                       span_vars[LEN_MAX][LEN_MAX];
   int                                string_len = 0;
   logic                              too_long = 1'b0;

   task automatic report_mismatch(input string what, input logic got, input logic want);
      $display("mismatch on %s: got %0b, expected %0b at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // fill every span that ends at position p
   task automatic fill_spans(input int p, input logic [cyk_mp_pkg::SYM_W-1:0] sym);
      int nb;
      int nt;
      logic [15:0] leaf;
      logic [15:0] vars;
      nb = (bin_count > BIN_SLOTS) ? BIN_SLOTS : int'(bin_count);
      nt = (term_count > TERM_SLOTS) ? TERM_SLOTS : int'(term_count);
      leaf = '0;
      for (int r = 0; r < nt; r++)
         if (term_sym[r] == sym) leaf[term_lhs[r]] = 1'b1;
      span_vars[p][p] = leaf;
      for (int j = p - 1; j >= 0; j--) begin
         vars = '0;
         for (int r = 0; r < nb; r++)
            for (int m = j; m < p; m++)
               if (span_vars[j][m][bin_left[r]] && span_vars[m+1][p][bin_right[r]])
                  vars[bin_lhs[r]] = 1'b1;
         span_vars[j][p] = vars;
      end
   endtask

   task automatic predict_parse(input parse_req_type t);
      verdict_type v;
      case (t.func)
         cyk_mp_pkg::FUNC_LOAD_BIN: begin
            bin_lhs[t.slot] = t.lhs;
            bin_left[t.slot] = t.first;
            bin_right[t.slot] = t.second;
         end
         cyk_mp_pkg::FUNC_LOAD_TERM: begin
            // slots past the table are dropped
            if (t.slot < TERM_SLOTS) begin
               term_lhs[t.slot] = t.lhs;
               term_sym[t.slot] = t.first;
            end
         end
         cyk_mp_pkg::FUNC_SYMBOL: begin
            if (string_len == 0 && !too_long)
               foreach (span_vars[a, b]) span_vars[a][b] = '0;
            if (string_len < LEN_MAX) begin
               fill_spans(string_len, t.sym);
               string_len++;
            end else begin
               too_long = 1'b1;
            end
            if (t.last) begin
               v.overflow = too_long;
               v.accepted = !too_long && string_len > 0 && span_vars[0][string_len-1][0];
               expected_verdicts.push_back(v);
               string_len = 0;
               too_long = 1'b0;
            end
         end
         default: ;
      endcase
   endtask

   // random gap: mostly none or short, now and then long; quiet stretches switch it off
   function automatic int pick_gap(input bit quiet);
      if (quiet) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   // request driver: holds the transaction until it is taken
   int drv_gap = 0;
   bit drv_quiet = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            predict_parse({req_func, req_rule_index, req_lhs_variable, req_rhs_first,
                           req_rhs_second, req_symbol, req_last_symbol});
         if (!req_valid || req_ready) begin
            if ($urandom_range(0, 99) == 0) drv_quiet = ~drv_quiet;
            if (drv_gap > 0) begin
               drv_gap <= drv_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               parse_req_type t;
               t = pending_reqs.pop_front();
               req_valid <= 1'b1;
               {req_func, req_rule_index, req_lhs_variable, req_rhs_first,
                req_rhs_second, req_symbol, req_last_symbol} <= t;
               drv_gap <= pick_gap(drv_quiet);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor with random back-pressure
   int mon_stall = 0;
   bit mon_quiet = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               report_mismatch("unexpected result", 1'b1, 1'b0);
            end else begin
               verdict_type v;
               v = expected_verdicts.pop_front();
               if (rsp_accepted !== v.accepted)
                  report_mismatch("accepted", rsp_accepted, v.accepted);
               if (rsp_overflow !== v.overflow)
                  report_mismatch("overflow", rsp_overflow, v.overflow);
            end
         end
         if ($urandom_range(0, 99) == 0) mon_quiet = ~mon_quiet;
         if (mon_stall > 0) begin
            mon_stall <= mon_stall - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            mon_stall <= pick_gap(mon_quiet);
         end
      end
   end

   // watchdog: cycles in which neither channel moves a transaction
   int stuck_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("[cyk_membership_parser_core] ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------
   int items_sent = 0;

   function automatic parse_req_type noise_req();
      parse_req_type t;
      t = parse_req_type'(REQ_W'({$urandom, $urandom}));
      return t;
   endfunction

   task automatic send_req(input parse_req_type t);
      pending_reqs.push_back(t);
      items_sent++;
   endtask

   task automatic send_rule(input logic [cyk_mp_pkg::FUNC_W-1:0] f, input int slot,
                            input int a, input int b, input int c);
      parse_req_type t;
      t = noise_req();
      t.func = f;
      t.slot = cyk_mp_pkg::RULE_IDX_W'(slot);
      t.lhs = cyk_mp_pkg::VAR_W'(a);
      t.first = cyk_mp_pkg::VAR_W'(b);
      t.second = cyk_mp_pkg::VAR_W'(c);
      send_req(t);
   endtask

   task automatic send_symbol(input int s, input bit last);
      parse_req_type t;
      t = noise_req();
      t.func = cyk_mp_pkg::FUNC_SYMBOL;
      t.sym = cyk_mp_pkg::SYM_W'(s);
      t.last = last;
      send_req(t);
   endtask

   // registers only change with nothing in flight
   task automatic wait_quiet();
      while (pending_reqs.size() > 0 || req_valid || expected_verdicts.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_counts(input int nb, input int nt);
      wait_quiet();
      csr_we <= 1'b1;
      csr_index <= cyk_mp_pkg::CSR_BIN_COUNT;
      csr_wdata <= cyk_mp_pkg::CSR_DATA_W'(nb);
      @(posedge clock);
      bin_count = cyk_mp_pkg::BIN_CNT_W'(nb);
      csr_index <= cyk_mp_pkg::CSR_TERM_COUNT;
      csr_wdata <= cyk_mp_pkg::CSR_DATA_W'(nt);
      @(posedge clock);
      term_count = cyk_mp_pkg::TERM_CNT_W'(nt);
      csr_we <= 1'b0;
   endtask

   // small variable and terminal sets make derivations likely
   function automatic int pick_var(input bit wide);
      return wide ? $urandom_range(0, 15) : $urandom_range(0, 3);
   endfunction

   task automatic random_bin_rule(input int slot, input bit wide);
      send_rule(cyk_mp_pkg::FUNC_LOAD_BIN, slot, pick_var(wide), pick_var(wide),
                pick_var(wide));
   endtask

   task automatic random_term_rule(input int slot, input bit wide);
      send_rule(cyk_mp_pkg::FUNC_LOAD_TERM, slot, pick_var(wide), pick_var(wide), 0);
   endtask

   task automatic random_string(input bit wide);
      int len;
      int pick;
      pick = $urandom_range(0, 19);
      if (pick == 0) len = $urandom_range(33, 36);       // past the chart
      else if (pick < 3) len = $urandom_range(20, 32);
      else len = $urandom_range(1, 8);
      for (int k = 0; k < len; k++) begin
         // occasional rule change or unused code in the middle of a string
         if ($urandom_range(0, 29) == 0)
            random_bin_rule($urandom_range(0, BIN_SLOTS - 1), wide);
         else if ($urandom_range(0, 39) == 0)
            send_rule(FUNC_UNUSED, $urandom_range(0, 63), 0, 0, 0);
         send_symbol(wide || $urandom_range(0, 9) == 0 ? $urandom_range(0, 15)
                                                          : $urandom_range(0, 3),
                     k == len - 1);
      end
   endtask

   initial begin
      int bin_steps[5];
      int term_steps[5];
      bit wide;
      bin_steps = '{64, 127, 0, 37, 64};
      term_steps = '{32, 63, 32, 0, 20};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: S -> A B, A -> 0, B -> 1
      send_rule(cyk_mp_pkg::FUNC_LOAD_BIN, 0, 0, 1, 2);
      send_rule(cyk_mp_pkg::FUNC_LOAD_TERM, 0, 1, 0, 0);
      send_rule(cyk_mp_pkg::FUNC_LOAD_TERM, 1, 2, 1, 0);
      send_rule(cyk_mp_pkg::FUNC_LOAD_TERM, 63, 15, 15, 15);   // slot past the table
      send_rule(FUNC_UNUSED, 63, 15, 15, 15);
      set_counts(1, 2);
      send_symbol(0, 0); send_symbol(1, 1);        // accepted
      send_symbol(0, 1);                           // single symbol, rejected
      send_symbol(1, 0); send_symbol(0, 1);        // wrong order
      send_symbol(15, 1);                          // symbol nobody derives
      send_symbol(0, 0);
      send_rule(cyk_mp_pkg::FUNC_LOAD_TERM, 1, 2, 15, 0);      // rule change mid-string
      send_symbol(15, 1);                          // now accepted
      send_symbol(0, 0); send_symbol(1, 0); send_symbol(1, 1);

      // fill every slot so any count is legal from here on
      for (int s = 0; s < BIN_SLOTS; s++) random_bin_rule(s, s >= 48);
      for (int s = 0; s < TERM_SLOTS; s++) random_term_rule(s, s >= 24);

      for (int ph = 0; ph < 5; ph++) begin
         set_counts(bin_steps[ph], term_steps[ph]);
         wide = (ph == 4);
         if (ph > 0)
            for (int k = 0; k < 12; k++) begin
               random_bin_rule($urandom_range(0, BIN_SLOTS - 1), wide);
               if (k % 3 == 0) random_term_rule($urandom_range(0, 63), wide);
            end
         while (items_sent < 120 * (ph + 1) - 80) random_string(wide || $urandom_range(0, 7) == 0);
      end

      wait_quiet();
      if (error_count == 0) begin
         $display("[cyk_membership_parser_core] OK");
      end else begin
         $display("[cyk_membership_parser_core] ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

### sim.f
+incdir+src
src/cyk_mp_pkg.sv
src/cyk_mp_chart.sv
src/cyk_mp_rules.sv
src/cyk_mp_seq.sv
src/cyk_membership_parser_core.sv
tb/tb.sv
